// File: rtl/core/first_fit_boundary_tag_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BOUNDARY_TAG_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define FFBTA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FFBTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/ffbta_pkg.sv
// Shared constants, types and the reset tag image for the allocator.
// No dependencies.
package ffbta_pkg;

  localparam int ARENA_GRANULES  = 4096;
  localparam int GRAN_W          = 12;   // granule index
  localparam int SIZE_W          = 13;   // block size and index sums
  localparam int TAG_W           = 17;   // size << 1 | allocated
  localparam int GRANULE_SHIFT   = 4;    // 16-byte granules
  localparam int TAG_GRANULES    = 2;
  localparam int SPLIT_MIN_EXTRA = 3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  typedef struct packed {
    logic              en;
    logic [GRAN_W-1:0] addr;
    logic [TAG_W-1:0]  data;
  } tag_wr_t;

  // Tag value of each granule after reset.
  function automatic logic [TAG_W-1:0] init_tag(input logic [GRAN_W-1:0] idx);
    logic [TAG_W-1:0] t;
    t = '0;
    if (idx == GRAN_W'(0) || idx == GRAN_W'(1))
      t = {16'(TAG_GRANULES), 1'b1};
    else if (idx == GRAN_W'(2) || idx == GRAN_W'(ARENA_GRANULES - 2))
      t = {16'(ARENA_GRANULES - 3), 1'b0};
    else if (idx == GRAN_W'(ARENA_GRANULES - 1))
      t = {16'd0, 1'b1};
    return t;
  endfunction

endpackage

// File: rtl/core/first_fit_boundary_tag_allocator.sv
// First-fit boundary-tag heap allocator over a 4096-granule arena.
// Depends on ffbta_pkg, ffbta_tag_ram and the assertion macro header.
//
// Usage:
//  - Request channel (in_valid/in_ready): op selects allocate or free;
//    req_bytes is used by allocate, block_addr by free.
//  - Result channel (out_valid/out_ready): one result per request with
//    addr (payload byte offset, zero unless an allocate succeeds) and status.
//  - One request is in flight at a time. The walk reads one block header at
//    a time from the tag RAM (issue read, evaluate registered data); a
//    successful allocate then writes two or four tags, and a successful
//    free reads the neighbor header and writes four tags. The next
//    request can be taken in the cycle after the result is registered.
//    The single tag RAM port pair paces the walk.
//  - Reset: an init pass writes the reset tag image (prologue, one free
//    block, terminator) into all 4096 RAM entries; in_ready stays low meanwhile.
//  - Receiver stall: a finished result sits in the output register and the
//    block takes the next request; it holds the following result until the
//    output register drains.
module first_fit_boundary_tag_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [15:0] req_bytes,
  input  logic [15:0] block_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] addr,
  output logic [1:0]  status
);
  import ffbta_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_NREAD = 3'd4;
  localparam logic [2:0] S_NEVAL = 3'd5;
  localparam logic [2:0] S_WRITE = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]        state;
  logic [GRAN_W-1:0] init_cnt;
  logic              req_op;
  logic [SIZE_W-1:0] need;
  logic [15:0]       req_addr;
  logic [GRAN_W-1:0] h;           // header being walked
  logic [GRAN_W-1:0] prev_h;
  logic [SIZE_W-1:0] prev_s;
  logic              prev_used;
  logic [SIZE_W-1:0] cur_s;       // size of block being freed
  logic [GRAN_W-1:0] nh;          // next header for merge check
  logic [GRAN_W-1:0] wq_addr [4];
  logic [TAG_W-1:0]  wq_data [4];
  logic [1:0]        wq_idx;
  logic [1:0]        wq_last;
  logic [15:0]       res_addr;
  logic [1:0]        res_status;

  tag_wr_t           wr;
  logic [GRAN_W-1:0] rd_addr;
  logic [TAG_W-1:0]  rd_data;

  ffbta_tag_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Decode of the header just read.
  logic [16:0]       t_s17;
  logic [16:0]       t_end;
  logic              t_ok;        // walk may continue through this block
  logic [SIZE_W-1:0] t_s;
  logic              t_alloc;
  logic [16:0]       need17;
  logic [SIZE_W-1:0] extra;
  logic [SIZE_W-1:0] h13;
  logic [16:0]       my_off;
  logic              prev_free;
  logic              next_free;
  logic [SIZE_W-1:0] start13;
  logic [SIZE_W-1:0] total;

  always_comb begin
    t_s17     = {1'b0, rd_data[TAG_W-1:1]};
    t_end     = 17'({5'b0, h}) + t_s17;
    if (state == S_NEVAL) t_end = 17'({5'b0, nh}) + t_s17;
    t_ok      = (t_s17 != 17'd0) && (t_end <= 17'(ARENA_GRANULES - 1));
    t_s       = rd_data[SIZE_W:1];
    t_alloc   = rd_data[0];
    need17    = {4'b0, need};
    extra     = t_s - need;
    h13       = {1'b0, h};
    my_off    = {SIZE_W'(h13 + SIZE_W'(1)), 4'b0};
    prev_free = !prev_used;
    next_free = !t_alloc && t_ok;
    start13   = prev_free ? {1'b0, prev_h} : h13;
    total     = cur_s + (prev_free ? prev_s : SIZE_W'(0)) + (next_free ? t_s : SIZE_W'(0));
  end

  always_comb begin
    rd_addr = (state == S_NREAD) ? nh : h;
    wr.en   = 1'b0;
    wr.addr = wq_addr[wq_idx];
    wr.data = wq_data[wq_idx];
    if (state == S_INIT) begin
      wr.en   = 1'b1;
      wr.addr = init_cnt;
      wr.data = init_tag(init_cnt);
    end else if (state == S_WRITE) begin
      wr.en = 1'b1;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      // Output register: load a finished result, or drain on handshake.
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_INIT: begin
          init_cnt <= init_cnt + GRAN_W'(1);
          if (init_cnt == GRAN_W'(ARENA_GRANULES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            req_op     <= op;
            need       <= SIZE_W'((17'(req_bytes) + 17'(15)) >> GRANULE_SHIFT)
                          + SIZE_W'(TAG_GRANULES);
            req_addr   <= block_addr;
            h          <= GRAN_W'(TAG_GRANULES);
            prev_h     <= '0;
            prev_s     <= SIZE_W'(TAG_GRANULES);
            prev_used  <= 1'b1;
            state      <= S_READ;
          end
        end
        S_READ:  state <= S_EVAL;
        S_EVAL: begin
          if (!t_ok) begin
            res_addr   <= '0;
            res_status <= (req_op == OP_ALLOC) ? ST_NOFIT : ST_BADFREE;
            state      <= S_DONE;
          end else if (req_op == OP_ALLOC) begin
            if (!t_alloc && t_s17 >= need17) begin
              res_addr   <= {GRAN_W'(h + GRAN_W'(1)), 4'b0};
              res_status <= ST_OK;
              if (extra > SIZE_W'(SPLIT_MIN_EXTRA)) begin
                wq_addr[0] <= h;
                wq_data[0] <= {16'(need), 1'b1};
                wq_addr[1] <= GRAN_W'(h13 + need - SIZE_W'(1));
                wq_data[1] <= {16'(need), 1'b1};
                wq_addr[2] <= GRAN_W'(h13 + need);
                wq_data[2] <= {16'(extra), 1'b0};
                wq_addr[3] <= GRAN_W'(h13 + t_s - SIZE_W'(1));
                wq_data[3] <= {16'(extra), 1'b0};
                wq_last    <= 2'd3;
              end else begin
                wq_addr[0] <= h;
                wq_data[0] <= {16'(t_s), 1'b1};
                wq_addr[1] <= GRAN_W'(h13 + t_s - SIZE_W'(1));
                wq_data[1] <= {16'(t_s), 1'b1};
                wq_last    <= 2'd1;
              end
              wq_idx <= '0;
              state  <= S_WRITE;
            end else begin
              h     <= GRAN_W'(h13 + t_s);
              state <= S_READ;
            end
          end else if (my_off == {1'b0, req_addr}) begin
            res_addr <= '0;
            if (!t_alloc) begin
              res_status <= ST_BADFREE;
              state      <= S_DONE;
            end else begin
              res_status <= ST_OK;
              cur_s      <= t_s;
              nh         <= GRAN_W'(h13 + t_s);
              state      <= S_NREAD;
            end
          end else begin
            prev_h     <= h;
            prev_s     <= t_s;
            prev_used  <= t_alloc;
            h          <= GRAN_W'(h13 + t_s);
            state      <= S_READ;
          end
        end
        S_NREAD: state <= S_NEVAL;
        S_NEVAL: begin
          // Four merge cases fold into start/total.
          wq_addr[0] <= h;
          wq_data[0] <= {16'(cur_s), 1'b0};
          wq_addr[1] <= GRAN_W'(h13 + cur_s - SIZE_W'(1));
          wq_data[1] <= {16'(cur_s), 1'b0};
          wq_addr[2] <= GRAN_W'(start13);
          wq_data[2] <= {16'(total), 1'b0};
          wq_addr[3] <= GRAN_W'(start13 + total - SIZE_W'(1));
          wq_data[3] <= {16'(total), 1'b0};
          wq_last    <= 2'd3;
          wq_idx     <= '0;
          state      <= S_WRITE;
        end
        S_WRITE: begin
          wq_idx <= wq_idx + 2'd1;
          if (wq_idx == wq_last) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            addr      <= res_addr;
            status    <= res_status;
            state     <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

`include "first_fit_boundary_tag_allocator_defines.svh"

  `FFBTA_ASSERT_NOW(a_wr_only_init_or_write, wr.en,
    (state == S_INIT || state == S_WRITE), "tag write outside init or write phase")
  `FFBTA_ASSERT_NOW(a_fail_addr_zero, out_valid && status != ST_OK,
    addr == 16'd0, "refused request returned nonzero addr")
  `FFBTA_ASSERT_NEXT(a_done_holds_when_full, state == S_DONE && out_valid && !out_ready,
    state == S_DONE, "result dropped while output stalled")

endmodule

// File: rtl/core/ffbta_tag_ram.sv
// Tag store: one write port, one read port, registered read data.
// Depends on ffbta_pkg.
module ffbta_tag_ram (
  input  logic                           clk,
  input  ffbta_pkg::tag_wr_t             wr,
  input  logic [ffbta_pkg::GRAN_W-1:0]   rd_addr,
  output logic [ffbta_pkg::TAG_W-1:0]    rd_data
);
  import ffbta_pkg::*;

  logic [TAG_W-1:0] mem [ARENA_GRANULES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
